// ----- hdl/tdcm_pkg.sv -----
// ----------------------------------------------------------------------------
// Time-window coincidence matcher: shared definitions
// Widths, codes, reset values and types used across the matcher's modules.
// ----------------------------------------------------------------------------
package tdcm_pkg;

    localparam int TS_W  = 48;
    localparam int EV_W  = 32;
    localparam int GAP_W = 21;
    localparam int WIN_W = 20;

    localparam int S_TDATA_W = 80;   // timestamp, event_number
    localparam int M_TDATA_W = 88;   // primary, secondary, time_gap, 3 pad bits
    localparam int M_TUSER_W = 2;    // hit, overflow

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int BUF_DEPTH_DEF   = 1024;
    localparam int MAX_MATCHES_DEF = 64;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000);

    // Register index as decoded from paddr[2]
    localparam logic REG_WINDOW = 1'b0;

    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic [EV_W-1:0] num;
        logic [TS_W-1:0] ts;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FIN
    } walk_state_t;

endpackage

// ----- hdl/tdcm_store.sv -----
// ----------------------------------------------------------------------------
// Secondary event store
// Single-port-write, single-port-read synchronous memory of stored events.
// ----------------------------------------------------------------------------
module tdcm_store
    import tdcm_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF,
    parameter int AW        = $clog2(BUF_DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [BUF_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while no read is issued, so a stalled walk keeps its entry.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/tdcm_walk.sv -----
// ----------------------------------------------------------------------------
// Store walker
// Accepts push and query beats, walks the store for each query and drives
// the result channel through an output register.
// ----------------------------------------------------------------------------
module tdcm_walk
    import tdcm_pkg::*;
#(
    parameter int BUF_DEPTH   = BUF_DEPTH_DEF,
    parameter int MAX_MATCHES = MAX_MATCHES_DEF,
    parameter int AW          = $clog2(BUF_DEPTH)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [WIN_W-1:0]     window,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output entry_t               wr_data,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  entry_t               rd_data
);

    localparam int NW = $clog2(MAX_MATCHES + 1);

    walk_state_t state_reg, state_next;

    logic [AW:0]        count_reg, count_next;
    logic [AW-1:0]      sp_reg, sp_next;
    logic [AW:0]        k_reg, k_next;
    logic [TS_W-1:0]    qtime_reg, qtime_next;
    logic [EV_W-1:0]    qev_reg, qev_next;
    logic [NW-1:0]      n_reg, n_next;
    logic               cut_reg, cut_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [EV_W-1:0]    pend_sec_reg, pend_sec_next;
    logic [GAP_W-1:0]   pend_gap_reg, pend_gap_next;

    logic               out_valid_reg, out_valid_next;
    logic [EV_W-1:0]    out_pri_reg, out_pri_next;
    logic [EV_W-1:0]    out_sec_reg, out_sec_next;
    logic [GAP_W-1:0]   out_gap_reg, out_gap_next;
    logic               out_hit_reg, out_hit_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_last_reg, out_last_next;

    logic               in_beat;
    logic               out_free;
    logic signed [TS_W:0] diff;
    logic signed [TS_W:0] win_ext;
    logic               is_match;
    logic               is_stop;
    logic               take;
    logic               stall;
    logic               last_entry;
    logic               start_ok;
    logic [AW:0]        k_inc;
    logic [AW:0]        k_dec;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // One wide subtract and three compares per visited entry
    assign diff     = $signed({1'b0, rd_data.ts}) - $signed({1'b0, qtime_reg});
    assign win_ext  = $signed({{(TS_W + 1 - WIN_W){1'b0}}, window});
    assign is_match = (diff >= -win_ext) && (diff <= win_ext);
    assign is_stop  = diff > win_ext;
    assign take     = is_match && (n_reg < NW'(MAX_MATCHES));
    assign stall    = take && pend_valid_reg && !out_free;

    assign k_inc      = k_reg + 1'b1;
    assign k_dec      = k_reg - 1'b1;
    assign last_entry = k_inc == count_reg;
    assign start_ok   = {1'b0, sp_reg} < count_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat && s_tuser == ACT_QUERY) begin
                    state_next = start_ok ? ST_READ : ST_FIN;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (!stall && (is_stop || last_entry)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        count_next      = count_reg;
        sp_next         = sp_reg;
        k_next          = k_reg;
        qtime_next      = qtime_reg;
        qev_next        = qev_reg;
        n_next          = n_reg;
        cut_next        = cut_reg;
        pend_valid_next = pend_valid_reg;
        pend_sec_next   = pend_sec_reg;
        pend_gap_next   = pend_gap_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_pri_next    = out_pri_reg;
        out_sec_next    = out_sec_reg;
        out_gap_next    = out_gap_reg;
        out_hit_next    = out_hit_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;

        s_tready    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        wr_data.ts  = s_tdata[TS_W-1:0];
        wr_data.num = s_tdata[TS_W +: EV_W];
        rd_en       = 1'b0;
        rd_addr     = k_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (in_beat) begin
                    if (s_tuser == ACT_QUERY) begin
                        qtime_next      = s_tdata[TS_W-1:0];
                        qev_next        = s_tdata[TS_W +: EV_W];
                        k_next          = {1'b0, sp_reg};
                        n_next          = '0;
                        cut_next        = 1'b0;
                        pend_valid_next = 1'b0;
                    end else if (count_reg < (AW + 1)'(BUF_DEPTH)) begin
                        // A push into a full store is dropped.
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_READ: begin
                rd_en = 1'b1;
            end
            ST_EVAL: begin
                if (!stall) begin
                    if (take) begin
                        n_next = n_reg + 1'b1;
                        // The previous match is known not to be the last one now.
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_pri_next   = qev_reg;
                            out_sec_next   = pend_sec_reg;
                            out_gap_next   = pend_gap_reg;
                            out_hit_next   = 1'b1;
                            out_ovf_next   = 1'b0;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sec_next   = rd_data.num;
                        pend_gap_next   = diff[GAP_W-1:0];
                    end else if (is_match) begin
                        cut_next = 1'b1;
                    end
                    if (is_stop) begin
                        sp_next = (k_reg != '0) ? k_dec[AW-1:0] : '0;
                    end else if (!last_entry) begin
                        k_next  = k_inc;
                        rd_en   = 1'b1;
                        rd_addr = k_inc[AW-1:0];
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_pri_next   = qev_reg;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        out_sec_next = pend_sec_reg;
                        out_gap_next = pend_gap_reg;
                        out_hit_next = 1'b1;
                        out_ovf_next = cut_reg;
                    end else begin
                        out_sec_next = '0;
                        out_gap_next = '0;
                        out_hit_next = 1'b0;
                        out_ovf_next = 1'b0;
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            sp_reg         <= sp_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        qtime_reg    <= qtime_next;
        qev_reg      <= qev_next;
        n_reg        <= n_next;
        cut_reg      <= cut_next;
        pend_sec_reg <= pend_sec_next;
        pend_gap_reg <= pend_gap_next;
        out_pri_reg  <= out_pri_next;
        out_sec_reg  <= out_sec_next;
        out_gap_reg  <= out_gap_next;
        out_hit_reg  <= out_hit_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_gap_reg, out_sec_reg, out_pri_reg};
    assign m_tuser  = {out_ovf_reg, out_hit_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- hdl/time_window_coincidence_matcher_top.sv -----
// Push beat: the block takes a push in every cycle while idle.
// Query beat: accepted while idle, then a memory read state, then one evaluation per
// visited store entry; the final beat is loaded in the finish state, which a walk
// that visits no entry enters straight from idle, once the result side is free.
// The store's single read port sets the pace of one entry per cycle, barring result stalls.
// Reset (synchronous, active low) empties the store and sets window to 1000; store
// contents stay undefined, and there is no clearing pass.
// ----------------------------------------------------------------------------
// Time-window coincidence matcher
// Pairs primary events with stored secondary events lying within a window.
// ----------------------------------------------------------------------------
module time_window_coincidence_matcher_top
    import tdcm_pkg::*;
#(
    parameter int BUF_DEPTH   = BUF_DEPTH_DEF,
    parameter int MAX_MATCHES = MAX_MATCHES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // timestamp[47:0], event_number[79:48]
    input  logic                  s_tuser,   // action
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // primary_event[31:0], secondary_event[63:32],
                                             // time_gap[84:64], zero pad[87:85]
    output logic [M_TUSER_W-1:0]  m_tuser,   // hit[0], overflow[1]
    output logic                  m_tlast
);

    localparam int AW = $clog2(BUF_DEPTH);

    logic [WIN_W-1:0] window_reg, window_next;
    logic             cfg_write;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    entry_t           rd_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        window_next = window_reg;
        if (cfg_write && paddr[2] == REG_WINDOW) begin
            window_next = pwdata[WIN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else begin
            window_reg <= window_next;
        end
    end

    assign prdata = (paddr[2] == REG_WINDOW) ?
                    {{(APB_DATA_W - WIN_W){1'b0}}, window_reg} : '0;

    tdcm_walk #(
        .BUF_DEPTH   (BUF_DEPTH),
        .MAX_MATCHES (MAX_MATCHES),
        .AW          (AW)
    ) u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .window   (window_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    tdcm_store #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // An empty query result is always the final beat of its query.
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("empty query result without last");

    // Overflow is flagged only on the final beat, and only after a match.
    a_ovf_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0])
        else $error("overflow flagged on a non-final or empty beat");

    // An empty query result carries no secondary event and no time gap.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[84:32] == '0)
        else $error("empty query result with non-zero payload");

    // A query beat starts a walk, so no further beat is taken in the next cycle.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_QUERY |=> !s_tready)
        else $error("input accepted during a walk");

endmodule

// ----- verif/time_window_coincidence_matcher_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Coincidence matcher testbench
// Drives push and query beats into the matcher and keeps its own model of the
// event store, the start pointer and the window. Every result beat is checked
// field by field against the pairs that the model works out for each query.
// A short table of hand-picked beats comes first, followed by random phases
// at several window settings and a few queries at the edges of the time range.
// ----------------------------------------------------------------------------
module time_window_coincidence_matcher_top_test;
    import tdcm_pkg::*;

    localparam logic [TS_W-1:0] MAX_TS = '1;
    localparam int QUIET_LIMIT = 8000;

    typedef struct packed {
        logic [EV_W-1:0]  pri;
        logic [EV_W-1:0]  sec;
        logic [GAP_W-1:0] gap;
        logic             hit;
        logic             ovf;
        logic             lst;
    } pair_t;

    typedef struct {
        logic            act;
        logic [TS_W-1:0] ts;
        logic [EV_W-1:0] ev;
        bit              fixed;
        pair_t           want;
    } probe_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // timestamp[47:0], event_number[79:48]
    logic                  s_tuser = 1'b0; // action
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;        // primary[31:0], secondary[63:32], time_gap[84:64]
    logic [M_TUSER_W-1:0]  m_tuser;        // hit[0], overflow[1]
    logic                  m_tlast;

    // Typed expectation travelling alongside the beat that is being offered
    bit    row_fixed = 1'b0;
    pair_t row_pair = '0;

    // Model of the matcher
    logic [TS_W-1:0]  store_ts [BUF_DEPTH_DEF];
    logic [EV_W-1:0]  store_ev [BUF_DEPTH_DEF];
    int unsigned      walk_from = 0;
    int unsigned      wr_slot = 0;
    int unsigned      stored = 0;
    logic [WIN_W-1:0] win = WINDOW_RESET;
    pair_t            pairs_due [$];

    int     mismatches = 0;
    int     quiet = 0;
    int     rx_hold = 0;
    bit     idle_on = 1'b1;
    longint now = 6000;

    time_window_coincidence_matcher_top dut (.*);

    always #1 aclk = ~aclk;

    // Works out the pairs for one accepted beat and queues them.
    function automatic void apply_beat(logic act, logic [TS_W-1:0] ts, logic [EV_W-1:0] ev);
        int unsigned oldest, idx, back;
        longint      gap, w;
        int          n;
        bit          cut, have_held;
        pair_t       held;
        if (act == ACT_PUSH) begin
            if (stored < BUF_DEPTH_DEF) begin
                store_ts[wr_slot] = ts;
                store_ev[wr_slot] = ev;
                wr_slot = (wr_slot + 1) % BUF_DEPTH_DEF;
                stored++;
            end
            return;
        end
        oldest = (wr_slot + BUF_DEPTH_DEF - stored) % BUF_DEPTH_DEF;
        w = longint'(win);
        n = 0;
        cut = 1'b0;
        have_held = 1'b0;
        held = '0;
        for (int unsigned k = (walk_from + BUF_DEPTH_DEF - oldest) % BUF_DEPTH_DEF;
             k < stored; k++) begin
            idx = (oldest + k) % BUF_DEPTH_DEF;
            gap = longint'(store_ts[idx]) - longint'(ts);
            if (gap >= -w && gap <= w) begin
                if (n < MAX_MATCHES_DEF) begin
                    if (have_held) pairs_due.push_back(held);
                    held = '{ev, store_ev[idx], gap[GAP_W-1:0], 1'b1, 1'b0, 1'b0};
                    have_held = 1'b1;
                    n++;
                end else begin
                    cut = 1'b1;
                end
            end
            if (gap > w) begin
                // The next walk resumes one entry short of the stop, never before the oldest.
                back = (k > 0) ? k - 1 : 0;
                walk_from = (oldest + back) % BUF_DEPTH_DEF;
                break;
            end
        end
        if (!have_held) held = '{ev, '0, '0, 1'b0, 1'b0, 1'b0};
        held.ovf = cut;
        held.lst = 1'b1;
        pairs_due.push_back(held);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        pair_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                apply_beat(s_tuser, s_tdata[TS_W-1:0], s_tdata[TS_W+EV_W-1:TS_W]);
                if (row_fixed) begin
                    void'(pairs_due.pop_back());
                    pairs_due.push_back(row_pair);
                end
            end
            if (m_tvalid && m_tready) begin
                if (pairs_due.size() == 0) begin
                    $error("result beat arrived with no pair pending");
                    mismatches++;
                end else begin
                    want = pairs_due.pop_front();
                    check_field("primary_event", want.pri, m_tdata[31:0]);
                    check_field("secondary_event", want.sec, m_tdata[63:32]);
                    check_field("time_gap", want.gap, m_tdata[84:64]);
                    check_field("hit", want.hit, m_tuser[0]);
                    check_field("overflow", want.ovf, m_tuser[1]);
                    check_field("last", want.lst, m_tlast);
                end
            end
        end
    end

    // Result-side back-pressure in bursts.
    always @(posedge aclk) begin
        if (!aresetn || !idle_on) begin
            rx_hold = 0;
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= (rx_hold == 0);
        end else if ($urandom_range(0, 9) == 0) begin
            rx_hold = $urandom_range(1, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_beat(input logic act, input logic [TS_W-1:0] ts,
                             input logic [EV_W-1:0] ev, input bit fixed, input pair_t want);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= act;
        s_tdata   <= {ev, ts};
        row_fixed <= fixed;
        row_pair  <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic reg_write(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_WINDOW) win = value[WIN_W-1:0];
        @(posedge aclk);
    endtask

    // Waits until every pair has come out, then waits on for a trailing push.
    // The first edge lets the model take in the beat accepted just before.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pairs_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(input int n_items, input int unsigned span, input int push_pct);
        int              pick;
        longint          ts;
        logic [63:0]     raw;
        logic [EV_W-1:0] ev;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            now += longint'($urandom_range(0, span));
            raw = {$urandom, $urandom};
            ev = $urandom;
            if (pick < 6) begin
                // Far off in time: the walk either covers everything or stops at once.
                send_beat(ACT_QUERY, raw[TS_W-1:0], ev, 1'b0, '0);
            end else if (pick < 10) begin
                ts = now - longint'($urandom_range(0, 4 * span));
                send_beat(ACT_PUSH, (ts < 0) ? '0 : ts[TS_W-1:0], ev, 1'b0, '0);
            end else if (pick < 10 + push_pct) begin
                send_beat(ACT_PUSH, now[TS_W-1:0], ev, 1'b0, '0);
            end else begin
                ts = now + longint'($urandom_range(0, 2 * span)) - longint'(span);
                send_beat(ACT_QUERY, (ts < 0) ? '0 : ts[TS_W-1:0], ev, 1'b0, '0);
            end
        end
    endtask

    // Window stays at its reset value of 1000 throughout this table.
    probe_t probe_table [13] = '{
        '{ACT_QUERY, 48'd0,    32'hFFFF_FFFF, 1'b1,
          '{32'hFFFF_FFFF, 32'd0, 21'd0, 1'b0, 1'b0, 1'b1}},
        '{ACT_PUSH,  48'd3000, 32'h0000_0000, 1'b0, '0},
        '{ACT_QUERY, 48'd0,    32'd5,         1'b1,
          '{32'd5, 32'd0, 21'd0, 1'b0, 1'b0, 1'b1}},
        '{ACT_PUSH,  48'd3000, 32'hFFFF_FFFF, 1'b0, '0},
        '{ACT_PUSH,  48'd4001, 32'h1234_5678, 1'b0, '0},
        '{ACT_QUERY, 48'd3000, 32'd0,         1'b0, '0},
        '{ACT_QUERY, 48'd5001, 32'd1,         1'b1,
          '{32'd1, 32'h1234_5678, -21'sd1000, 1'b1, 1'b0, 1'b1}},
        '{ACT_QUERY, 48'd3001, 32'd2,         1'b0, '0},
        '{ACT_QUERY, MAX_TS,   32'd3,         1'b1,
          '{32'd3, 32'd0, 21'd0, 1'b0, 1'b0, 1'b1}},
        '{ACT_QUERY, 48'd4001, 32'hFFFF_FFFF, 1'b1,
          '{32'hFFFF_FFFF, 32'h1234_5678, 21'd0, 1'b1, 1'b0, 1'b1}},
        '{ACT_PUSH,  48'd5000, 32'hA5A5_A5A5, 1'b0, '0},
        '{ACT_QUERY, 48'd4000, 32'd6,         1'b0, '0},
        '{ACT_QUERY, 48'd2000, 32'd7,         1'b0, '0}
    };

    initial begin
        logic [63:0]     raw;
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probe_table[i])
            send_beat(probe_table[i].act, probe_table[i].ts, probe_table[i].ev,
                      probe_table[i].fixed, probe_table[i].want);
        run_phase(90, 300, 50);
        settle();

        // A write to an unmapped register must leave the window alone.
        reg_write(~REG_WINDOW, $urandom);
        reg_write(REG_WINDOW, '0);
        run_phase(60, 1, 50);
        settle();

        // Widest window with dense pushes, so that queries run past the match limit.
        reg_write(REG_WINDOW, APB_DATA_W'(20'hF_FFFF));
        run_phase(120, 4096, 65);
        settle();

        idle_on = 1'b0;
        reg_write(REG_WINDOW, APB_DATA_W'($urandom_range(0, 20'hF_FFFF)));
        run_phase(60, win / 4 + 1, 50);
        settle();

        // Queries at both ends of the time range with the widest window.
        reg_write(REG_WINDOW, APB_DATA_W'(20'hF_FFFF));
        raw = {$urandom, $urandom};
        send_beat(ACT_QUERY, MAX_TS, $urandom, 1'b0, '0);
        send_beat(ACT_QUERY, MAX_TS - 48'd20000, $urandom, 1'b0, '0);
        send_beat(ACT_QUERY, raw[TS_W-1:0], $urandom, 1'b0, '0);
        send_beat(ACT_QUERY, 48'd0, $urandom, 1'b0, '0);
        send_beat(ACT_QUERY, MAX_TS - 48'd1000, $urandom, 1'b0, '0);
        settle();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
